FILE: design/tule_pkg.sv
// Package for the tick unwrap / latency estimator: field widths, default parameters,
// and the packed item types of both channels. No dependencies.
package tule_pkg;

  localparam int TICK_W   = 32;
  localparam int TIME_W   = 56;
  localparam int UNW_W    = 40;
  localparam int DELTA_W  = 31;
  localparam int EXCESS_W = 40;

  // The scaled count saturates at 2^SCALE_CAP_W - 1
  localparam int SCALE_CAP_W = 62;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 40;

  // A tick difference at or above this limit marks a remote restart
  localparam logic [TICK_W-1:0] RESTART_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [TICK_W-1:0] remote_tick;
    logic [TIME_W-1:0] host_time;
  } in_t;

  typedef struct packed {
    logic [UNW_W-1:0]    unwrapped_tick;
    logic [DELTA_W-1:0]  tick_delta;
    logic                restarted;
    logic [EXCESS_W-1:0] excess_delay;
  } out_t;

endpackage

FILE: design/tick_unwrap_latency_estimator_top.sv
// An accepted item waits in the input register until the result register is free,
// then its result is registered. Throughput: one item per clock unless the output
// stalls; unwrap, offset and minimum update run in one pass between the registers.
// Reset (rst_ni low, asynchronous): both stages empty, first-item flag cleared,
// last tick, tick count and minimum offset cleared to zero.
module tick_unwrap_latency_estimator_top
  import tule_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Scaled count width before saturation, and after it
  localparam int PW       = COUNT_BITS + FRAC_BITS;
  localparam int PW_EXT   = (PW > SCALE_CAP_W) ? PW : SCALE_CAP_W + 1;
  localparam int SCALE_W  = (PW < SCALE_CAP_W) ? PW : SCALE_CAP_W;
  localparam int OFF_W    = ((SCALE_W > TIME_W) ? SCALE_W : TIME_W) + 1;
  localparam int CNT_EXT  = (COUNT_BITS > UNW_W) ? COUNT_BITS : UNW_W;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
  localparam logic [SCALE_CAP_W-1:0] SCALE_CAP  = '1;
  localparam logic [EXCESS_W-1:0]    EXCESS_MAX = '1;

  // Input stage
  logic s1_valid_q;
  in_t  s1_data_q;

  // Estimator state
  logic                           seen_first_q, seen_first_d;
  logic [TICK_W-1:0]              last_tick_q, last_tick_d;
  logic [COUNT_BITS-1:0]          count_q, count_d;
  logic signed [OFF_W-1:0]        min_off_q, min_off_d;

  // Result stage
  logic out_valid_q;
  out_t out_data_q, out_data_d;

  logic advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // Datapath
  logic [TICK_W-1:0]       tick_diff;
  logic                    restart;
  logic                    reload;
  logic [COUNT_BITS:0]     count_sum;
  logic [PW_EXT-1:0]       scaled_ext;
  logic [SCALE_CAP_W-1:0]  scaled;
  logic signed [OFF_W-1:0] offset;
  logic signed [OFF_W:0]   off_diff;
  logic [OFF_W-1:0]        off_diff_u;
  logic [EXCESS_W-1:0]     excess;
  logic [CNT_EXT-1:0]      count_ext;

  always_comb begin
    tick_diff = s1_data_q.remote_tick - last_tick_q;
    restart   = seen_first_q && (tick_diff >= RESTART_LIMIT);
    reload    = !seen_first_q || restart;

    count_sum = {1'b0, count_q} + (COUNT_BITS+1)'(tick_diff);
    if (reload) begin
      count_d = COUNT_BITS'(s1_data_q.remote_tick);
    end else if (count_sum[COUNT_BITS]) begin
      count_d = COUNT_MAX;
    end else begin
      count_d = count_sum[COUNT_BITS-1:0];
    end

    // offset = host time minus count in fixed point, with the scaled count capped
    scaled_ext = PW_EXT'(count_d) << FRAC_BITS;
    if (|scaled_ext[PW_EXT-1:SCALE_CAP_W]) begin
      scaled = SCALE_CAP;
    end else begin
      scaled = scaled_ext[SCALE_CAP_W-1:0];
    end
    offset = signed'(OFF_W'(s1_data_q.host_time)) - signed'(OFF_W'(scaled));

    off_diff   = {offset[OFF_W-1], offset} - {min_off_q[OFF_W-1], min_off_q};
    off_diff_u = off_diff[OFF_W-1:0];

    excess = '0;
    if (!reload && (offset > min_off_q)) begin
      if (|off_diff_u[OFF_W-1:EXCESS_W]) begin
        excess = EXCESS_MAX;
      end else begin
        excess = off_diff_u[EXCESS_W-1:0];
      end
    end

    if (reload || (offset < min_off_q)) begin
      min_off_d = offset;
    end else begin
      min_off_d = min_off_q;
    end

    seen_first_d = 1'b1;
    last_tick_d  = s1_data_q.remote_tick;

    count_ext                 = CNT_EXT'(count_d);
    out_data_d.unwrapped_tick = count_ext[UNW_W-1:0];
    out_data_d.tick_delta     = reload ? '0 : tick_diff[DELTA_W-1:0];
    out_data_d.restarted      = restart;
    out_data_d.excess_delay   = excess;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      seen_first_q <= 1'b0;
      last_tick_q  <= '0;
      count_q      <= '0;
      min_off_q    <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        seen_first_q <= seen_first_d;
        last_tick_q  <= last_tick_d;
        count_q      <= count_d;
        min_off_q    <= min_off_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A restart carries no forward advance and no excess delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.restarted) |->
      (out_data_o.tick_delta == '0 && out_data_o.excess_delay == '0))
    else $error("restart item with nonzero delta or excess");

  // Input side only stalls when a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result stage");

  // A staged item with a free result slot lands in the result register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("staged item not moved to result register");

  // The first item after reset is never flagged as a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !seen_first_q) |=> !out_data_o.restarted)
    else $error("first item flagged as restart");
`endif

endmodule
